### hw/rtl/fxn_pkg.sv
// fxn_pkg: shared types and constants of the filtered-x nlms adaptive fir
// used by fxn_div, fxnlms_adaptive_filter and the testbench; depends on nothing
`default_nettype none

package fxn_pkg;

   localparam int SAMPLE_W   = 24;   // q1.23 samples
   localparam int WEIGHT_W   = 32;   // q4.27 weights and step vector entries
   localparam int STEP_W     = 16;   // mu in q0.16
   localparam int REG_W      = 32;   // regularizer
   localparam int GAIN_W     = 40;   // q.32 gain, saturated to all ones
   localparam int DIVIDEND_W = 78;   // num << shift, same width for both gain forms
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TAPS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REG  = 2'd2;

   typedef enum logic [1:0] {
      OP_FILTER  = 2'd0,
      OP_UPDATE  = 2'd1,
      OP_PRECOMP = 2'd2,
      OP_APPLY   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HWRITE,
      ST_EPASS,
      ST_EDRAIN,
      ST_DIV,
      ST_WPASS,
      ST_WDRAIN,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/fxn_ram.sv
// fxn_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module fxn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### hw/rtl/fxn_div.sv
// fxn_div: restoring divider, one quotient bit per cycle, saturating gain result
// depends on fxn_pkg
`default_nettype none

module fxn_div import fxn_pkg::*; #(
   parameter int DEN_W = 54
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DEN_W-1:0]      divisor,
   output logic                       done,
   output logic      [GAIN_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [GAIN_W-1:0]     q_ff, q_in;
   logic                  ovf_ff, ovf_in;
   logic [DEN_W:0]        trial;
   logic                  ge;

   always_comb begin
      trial   = {rem_ff, num_ff[DIVIDEND_W-1]};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         q_in    = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         num_in = {num_ff[DIVIDEND_W-2:0], 1'b0};
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         // any bit pushed past the top means the gain saturates
         ovf_in = ovf_ff | q_ff[GAIN_W-1];
         q_in   = {q_ff[GAIN_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

   assign done     = done_ff;
   assign quotient = ovf_ff ? {GAIN_W{1'b1}} : q_ff;

endmodule

`default_nettype wire

### hw/rtl/fxnlms_adaptive_filter.sv
// fxnlms_adaptive_filter: filtered-x nlms adaptive fir, top level
// depends on fxn_pkg, fxn_ram (histories, weights/step vector), fxn_div
//
//   channel | dir | handshake               | payload
//   req     | in  | req_tvalid/req_tready   | req_tdata: type, ref, filtered ref, error
//   rsp     | out | rsp_tvalid/rsp_tready   | rsp_tdata: control_out
//   csr     | in  | csr_valid/csr_ready     | csr_index, csr_data
//
// one item at a time, N = taps in use; one multiplier walks the taps, one tap a cycle
// filter: history write, weight pass; apply: weight pass; update and precompute: energy
// pass, divider, weight pass
// after reset and after a taps_in_use write a clearing pass over all MAX_TAPS entries
// zeroes both memories; req_tready stays low meanwhile, csr writes are always taken
// a filter result sits in an output register; the next item is taken while it waits
`default_nettype none

module fxnlms_adaptive_filter import fxn_pkg::*; #(
   parameter int MAX_TAPS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // [1:0] req_type, [25:2] ref_sample, [49:26] filtered_ref, [73:50] error_sample
   input  wire logic [79:0]          req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // [23:0] control_out
   output logic      [23:0]          rsp_tdata,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data
);

   localparam int AW    = $clog2(MAX_TAPS);
   localparam int NW    = $clog2(MAX_TAPS + 1);
   localparam int EW    = 47 + NW;
   localparam int ACC_W = 56 + NW;
   localparam int TAPS_DEF = (64 > MAX_TAPS) ? MAX_TAPS : 64;
   localparam logic [NW-1:0] TAPS_RST = NW'(TAPS_DEF);

   state_type state_ff, state_in;

   logic [NW-1:0]           taps_ff, taps_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [REG_W-1:0]        reg_ff, reg_in;
   logic [AW-1:0]           wi_ff, wi_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [AW-1:0]           k_ff, k_in;
   logic [AW-1:0]           p_ff, p_in;
   logic                    ephase_ff, ephase_in;
   op_type                  op_ff, op_in;
   logic [SAMPLE_W-1:0]     ref_ff, ref_in;
   logic [SAMPLE_W-1:0]     flt_ff, flt_in;
   logic [SAMPLE_W-1:0]     err_ff, err_in;
   logic [EW-1:0]           en_ff, en_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [GAIN_W-1:0]       gain_ff, gain_in;
   logic                    s1_ff, s1_in;
   logic [AW-1:0]           k1_ff, k1_in;
   logic                    s2_ff, s2_in;
   logic [AW-1:0]           k2_ff, k2_in;
   logic [63:0]             prod2_ff, prod2_in;
   logic                    neg2_ff, neg2_in;
   logic [WEIGHT_W-1:0]     w2_ff, w2_in;
   logic [WEIGHT_W-1:0]     sv2_ff, sv2_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                    issue, hwr, div_start, div_done, load_rsp, en_init, acc_clr;
   logic [AW-1:0]           wi_next;
   logic [NW-1:0]           n_cfg;
   logic [GAIN_W-1:0]       div_q;
   logic [38:0]             upd_num;
   logic [DIVIDEND_W-1:0]   dividend;

   logic [47:0]             h_rd;
   logic [63:0]             w_rd;
   logic                    h_wen, w_wen;
   logic [AW-1:0]           h_waddr, w_waddr;
   logic [47:0]             h_wdata;
   logic [63:0]             w_wdata;

   logic [SAMPLE_W-1:0]     mul_a;
   logic [GAIN_W-1:0]       mul_b;
   logic [SAMPLE_W-1:0]     h_ref, h_flt;
   logic [WEIGHT_W-1:0]     w_old, sv_old;

   logic [41:0]             rnd;
   logic signed [42:0]      dsig;
   logic signed [43:0]      wdiff;
   logic [WEIGHT_W-1:0]     w_new, sv_new;
   logic signed [55:0]      term;

   logic [ACC_W-1:0]        acc_mag;
   logic [ACC_W-27:0]       acc_rnd;
   logic signed [ACC_W-25:0] acc_y;
   logic [SAMPLE_W-1:0]     y_sat;

   function automatic logic [SAMPLE_W-1:0] mag24(input logic [SAMPLE_W-1:0] v);
      mag24 = v[SAMPLE_W-1] ? SAMPLE_W'(-v) : v;
   endfunction

   function automatic logic [WEIGHT_W-1:0] mag32(input logic [WEIGHT_W-1:0] v);
      mag32 = v[WEIGHT_W-1] ? WEIGHT_W'(-v) : v;
   endfunction

   function automatic logic [WEIGHT_W-1:0] sat32(input logic signed [43:0] v);
      if (v > 44'sd2147483647) begin
         sat32 = 32'h7fff_ffff;
      end else if (v < -44'sd2147483648) begin
         sat32 = 32'h8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   // ---------------------------------------------------------------- memories
   // history word: filtered ref in the upper half, ref in the lower
   fxn_ram #(.WIDTH(48), .DEPTH(MAX_TAPS)) u_hist (
      .clock   (clock),
      .wr_en   (h_wen),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_addr (p_ff),
      .rd_data (h_rd)
   );

   // weight word: step vector entry in the upper half, weight in the lower
   fxn_ram #(.WIDTH(64), .DEPTH(MAX_TAPS)) u_wgt (
      .clock   (clock),
      .wr_en   (w_wen),
      .wr_addr (w_waddr),
      .wr_data (w_wdata),
      .rd_addr (k_ff),
      .rd_data (w_rd)
   );

   // ---------------------------------------------------------------- divider
   assign upd_num  = 39'(step_ff * mag24(err_ff));
   assign dividend = (op_ff == OP_UPDATE) ? {upd_num, 39'd0} : {step_ff, 62'd0};

   fxn_div #(.DEN_W(EW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (en_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // ---------------------------------------------------------------- sequencer
   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      if (csr_data[6:0] == 7'd0) begin
         n_cfg = NW'(1);
      end else if (int'(csr_data[6:0]) > MAX_TAPS) begin
         n_cfg = NW'(MAX_TAPS);
      end else begin
         n_cfg = NW'(csr_data[6:0]);
      end
      wi_next = ((NW'(wi_ff) + NW'(1)) >= taps_ff) ? '0 : AW'(wi_ff + AW'(1));
   end

   always_comb begin
      state_in  = state_ff;
      taps_in   = taps_ff;
      step_in   = step_ff;
      reg_in    = reg_ff;
      wi_in     = wi_ff;
      clr_in    = clr_ff;
      k_in      = k_ff;
      p_in      = p_ff;
      ephase_in = ephase_ff;
      op_in     = op_ff;
      ref_in    = ref_ff;
      flt_in    = flt_ff;
      err_in    = err_ff;
      gain_in   = gain_ff;
      issue     = 1'b0;
      hwr       = 1'b0;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      en_init   = 1'b0;
      acc_clr   = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_TAPS - 1)) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in  = op_type'(req_tdata[1:0]);
               ref_in = req_tdata[25:2];
               flt_in = req_tdata[49:26];
               err_in = req_tdata[73:50];
               k_in   = '0;
               p_in   = wi_ff;
               unique case (op_type'(req_tdata[1:0]))
                  OP_FILTER: state_in = ST_HWRITE;
                  OP_APPLY:  state_in = ST_WPASS;
                  OP_UPDATE, OP_PRECOMP: begin
                     ephase_in = 1'b1;
                     en_init   = 1'b1;
                     state_in  = ST_EPASS;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_HWRITE: begin
            hwr      = 1'b1;
            wi_in    = wi_next;
            p_in     = wi_next;
            k_in     = '0;
            acc_clr  = 1'b1;
            state_in = ST_WPASS;
         end
         ST_EPASS, ST_WPASS: begin
            issue = 1'b1;
            k_in  = k_ff + AW'(1);
            p_in  = (p_ff == '0) ? AW'(taps_ff - NW'(1)) : AW'(p_ff - AW'(1));
            if (NW'(k_ff) == taps_ff - NW'(1)) begin
               state_in = (state_ff == ST_EPASS) ? ST_EDRAIN : ST_WDRAIN;
            end
         end
         ST_EDRAIN: begin
            if (!s1_ff && !s2_ff) begin
               div_start = 1'b1;
               ephase_in = 1'b0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               gain_in  = div_q;
               k_in     = '0;
               p_in     = wi_ff;
               state_in = ST_WPASS;
            end
         end
         ST_WDRAIN: begin
            if (!s1_ff && !s2_ff) begin
               state_in = (op_ff == OP_FILTER) ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_valid) begin
         unique case (csr_index)
            CSR_TAPS: begin
               taps_in  = n_cfg;
               wi_in    = AW'(n_cfg - NW'(1));
               clr_in   = '0;
               state_in = ST_CLEAR;
            end
            CSR_STEP: step_in = csr_data[STEP_W-1:0];
            CSR_REG:  reg_in  = csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- tap pipeline
   // stage 1: read data back, one shared multiply on magnitudes
   always_comb begin
      h_ref  = h_rd[23:0];
      h_flt  = h_rd[47:24];
      w_old  = w_rd[31:0];
      sv_old = w_rd[63:32];
      if (ephase_ff) begin
         mul_a   = mag24(h_flt);
         mul_b   = GAIN_W'(mag24(h_flt));
         neg2_in = 1'b0;
      end else begin
         case (op_ff)
            OP_FILTER: begin
               mul_a   = mag24(h_ref);
               mul_b   = GAIN_W'(mag32(w_old));
               neg2_in = h_ref[SAMPLE_W-1] ^ w_old[WEIGHT_W-1];
            end
            OP_UPDATE: begin
               mul_a   = mag24(h_flt);
               mul_b   = gain_ff;
               neg2_in = err_ff[SAMPLE_W-1] ^ h_flt[SAMPLE_W-1];
            end
            OP_PRECOMP: begin
               mul_a   = mag24(h_flt);
               mul_b   = gain_ff;
               neg2_in = h_flt[SAMPLE_W-1];
            end
            default: begin
               mul_a   = mag24(err_ff);
               mul_b   = GAIN_W'(mag32(sv_old));
               neg2_in = err_ff[SAMPLE_W-1] ^ sv_old[WEIGHT_W-1];
            end
         endcase
      end
      prod2_in = 64'(mul_a) * 64'(mul_b);
      w2_in    = w_old;
      sv2_in   = sv_old;
      s1_in    = issue;
      k1_in    = k_ff;
      s2_in    = s1_ff;
      k2_in    = k1_ff;
   end

   // stage 2: accumulate, or round, subtract (not for precompute), saturate and write back
   always_comb begin
      term = $signed({1'b0, prod2_ff[54:0]});
      if (acc_clr) begin
         acc_in = '0;
      end else if (s2_ff && !ephase_ff && op_ff == OP_FILTER) begin
         acc_in = neg2_ff ? acc_ff - ACC_W'(term) : acc_ff + ACC_W'(term);
      end else begin
         acc_in = acc_ff;
      end

      if (en_init) begin
         en_in = EW'({reg_ff, 14'd0});
      end else if (s2_ff && ephase_ff) begin
         en_in = en_ff + EW'(prod2_ff[46:0]);
      end else begin
         en_in = en_ff;
      end

      if (op_ff == OP_APPLY) begin
         rnd = 42'(prod2_ff[63:23]) + 42'(prod2_ff[22]);
      end else begin
         rnd = 42'(prod2_ff[63:28]) + 42'(prod2_ff[27]);
      end
      dsig   = neg2_ff ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
      wdiff  = 44'($signed(w2_ff)) - 44'(dsig);
      w_new  = sat32(wdiff);
      sv_new = sat32(44'(dsig));
   end

   // filter output: round half away from zero, then clamp to 24 bits
   always_comb begin
      acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      acc_rnd = (ACC_W-26)'(acc_mag[ACC_W-1:27]) + (ACC_W-26)'(acc_mag[26]);
      acc_y   = acc_ff[ACC_W-1] ? -$signed({1'b0, acc_rnd}) : $signed({1'b0, acc_rnd});
      if (acc_y > (ACC_W-24)'(24'sh7fffff)) begin
         y_sat = 24'h7fffff;
      end else if (acc_y < -(ACC_W-24)'(25'sh0800000)) begin
         y_sat = 24'h800000;
      end else begin
         y_sat = acc_y[23:0];
      end
      rsp_data_in  = load_rsp ? y_sat : rsp_data_ff;
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // memory write ports
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         h_wen   = 1'b1;
         h_waddr = clr_ff;
         h_wdata = '0;
         w_wen   = 1'b1;
         w_waddr = clr_ff;
         w_wdata = '0;
      end else begin
         h_wen   = hwr;
         h_waddr = wi_next;
         h_wdata = {flt_ff, ref_ff};
         w_wen   = s2_ff && !ephase_ff && op_ff != OP_FILTER;
         w_waddr = k2_ff;
         w_wdata = (op_ff == OP_PRECOMP) ? {sv_new, w2_ff} : {sv2_ff, w_new};
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         taps_ff      <= TAPS_RST;
         step_ff      <= STEP_W'(16384);
         reg_ff       <= REG_W'(429497);
         wi_ff        <= AW'(TAPS_RST - NW'(1));
         clr_ff       <= '0;
         ephase_ff    <= 1'b0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         taps_ff      <= taps_in;
         step_ff      <= step_in;
         reg_ff       <= reg_in;
         wi_ff        <= wi_in;
         clr_ff       <= clr_in;
         ephase_ff    <= ephase_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      p_ff        <= p_in;
      op_ff       <= op_in;
      ref_ff      <= ref_in;
      flt_ff      <= flt_in;
      err_ff      <= err_in;
      en_ff       <= en_in;
      acc_ff      <= acc_in;
      gain_ff     <= gain_in;
      k1_ff       <= k1_in;
      k2_ff       <= k2_in;
      prod2_ff    <= prod2_in;
      neg2_ff     <= neg2_in;
      w2_ff       <= w2_in;
      sv2_ff      <= sv2_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### dv/testbench.sv
// testbench: self-checking bench for fxnlms_adaptive_filter (filtered-x nlms fir)
// depends on fxn_pkg and the rtl; predicts every control_out with its own fixed-point model
`default_nettype none

module testbench;
   import fxn_pkg::*;

   localparam int TAPS_MAX    = 64;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE      = 300;   // longest items are update and precompute
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [79:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [23:0]          rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   fxnlms_adaptive_filter #(.MAX_TAPS(TAPS_MAX)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // filter model state
   longint      ref_hist[TAPS_MAX];
   longint      filt_hist[TAPS_MAX];
   longint      wts[TAPS_MAX];
   longint      stepv[TAPS_MAX];
   int unsigned widx;
   int unsigned ntaps;
   bit [63:0]   mu;
   bit [63:0]   floor_energy;

   logic [23:0] control_expected[$];
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          cycles = 0;

   function automatic longint sat_to(longint v, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
   endfunction

   function automatic bit [63:0] mag_of(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint round_mag(bit [63:0] m, int sh, bit neg);
      bit [63:0] r;
      r = (m >> sh) + ((m >> (sh - 1)) & 64'd1);
      return neg ? -longint'(r) : longint'(r);
   endfunction

   // floor(num * 2^sh / den) with a 40-bit cap
   function automatic bit [63:0] gain_quot(bit [63:0] num, int sh, bit [63:0] den);
      bit [63:0] cap;
      bit [63:0] q;
      bit [63:0] r;
      cap = (64'd1 << 40) - 1;
      if (den == 0) return cap;
      q = num / den;
      r = num % den;
      if (q > cap) return cap;
      for (int i = 0; i < sh; i++) begin
         q = q << 1;
         if (r >= den - r) begin
            r = r - (den - r);
            q = q | 64'd1;
         end else begin
            r = r << 1;
         end
         if (q > cap) return cap;
      end
      return q;
   endfunction

   function automatic int unsigned tap_slot(int unsigned k);
      return widx >= k ? widx - k : widx + ntaps - k;
   endfunction

   function automatic bit [63:0] history_energy();
      bit [63:0] e;
      e = floor_energy << 14;
      for (int k = 0; k < ntaps; k++) e += mag_of(filt_hist[k]) * mag_of(filt_hist[k]);
      return e;
   endfunction

   function automatic void clear_filter();
      for (int k = 0; k < TAPS_MAX; k++) begin
         ref_hist[k] = 0;
         filt_hist[k] = 0;
         wts[k] = 0;
         stepv[k] = 0;
      end
      widx = ntaps - 1;
   endfunction

   function automatic void model_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      int unsigned n;
      case (idx)
         CSR_TAPS: begin
            n = val[6:0];
            if (n == 0) n = 1;
            if (n > TAPS_MAX) n = TAPS_MAX;
            ntaps = n;
            clear_filter();
         end
         CSR_STEP: mu = val[15:0];
         CSR_REG:  floor_energy = val;
         default: ;
      endcase
   endfunction

   function automatic void model_item(op_type op, logic signed [23:0] xs,
                                      logic signed [23:0] fs, logic signed [23:0] es);
      longint    acc;
      longint    s;
      longint    err;
      bit [63:0] g;
      err = es;
      case (op)
         OP_FILTER: begin
            acc = 0;
            widx = (widx + 1 >= ntaps) ? 0 : widx + 1;
            ref_hist[widx] = xs;
            filt_hist[widx] = fs;
            for (int k = 0; k < ntaps; k++) acc += ref_hist[tap_slot(k)] * wts[k];
            acc = sat_to(round_mag(mag_of(acc), 27, acc < 0), 24);
            control_expected.push_back(acc[23:0]);
         end
         OP_UPDATE: begin
            g = gain_quot(mu * mag_of(err), 39, history_energy());
            for (int k = 0; k < ntaps; k++) begin
               s = filt_hist[tap_slot(k)];
               wts[k] = sat_to(wts[k] - round_mag(g * mag_of(s), 28, (err < 0) != (s < 0)), 32);
            end
         end
         OP_PRECOMP: begin
            g = gain_quot(mu, 62, history_energy());
            for (int k = 0; k < ntaps; k++) begin
               s = filt_hist[tap_slot(k)];
               stepv[k] = sat_to(round_mag(g * mag_of(s), 28, s < 0), 32);
            end
         end
         default: begin
            for (int k = 0; k < ntaps; k++) begin
               acc = err * stepv[k];
               wts[k] = sat_to(wts[k] - round_mag(mag_of(acc), 23, acc < 0), 32);
            end
         end
      endcase
   endfunction

   task automatic send_item(op_type op, logic signed [23:0] xs,
                            logic signed [23:0] fs, logic signed [23:0] es);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {6'd0, es, fs, xs, op};
      do @(posedge clock); while (!req_tready);
      model_item(op, xs, fs, es);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // wait until the block is idle before touching registers
   task automatic drain();
      wait (control_expected.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      model_csr(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic signed [23:0] rand_sample();
      logic signed [23:0] v;
      v = 24'($urandom);
      case ($urandom_range(9))
         0: v = 24'sh7FFFFF;
         1: v = 24'sh800000;
         2, 3: ;
         default: v = v >>> $urandom_range(16, 3);
      endcase
      return v;
   endfunction

   // checker: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (control_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result control_out=%h", rsp_tdata);
         end else begin
            if (rsp_tdata !== control_expected[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("control_out expected %h got %h", control_expected[0], rsp_tdata);
            end
            void'(control_expected.pop_front());
         end
      end
   end

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   task automatic test_filter_extremes();
      send_item(OP_FILTER, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh0);
      send_item(OP_FILTER, 24'sh800000, 24'sh800000, 24'sh0);
      send_item(OP_UPDATE, 24'sh0, 24'sh0, 24'sh7FFFFF);
      send_item(OP_FILTER, 24'sh7FFFFF, 24'sh800000, 24'sh0);
      send_item(OP_UPDATE, 24'sh0, 24'sh0, 24'sh800000);
      send_item(OP_FILTER, 24'sh800000, 24'sh7FFFFF, 24'sh0);
      send_item(OP_FILTER, 24'sh000001, 24'shFFFFFF, 24'sh0);
   endtask

   task automatic test_two_phase();
      send_item(OP_PRECOMP, 24'sh0, 24'sh0, 24'sh0);
      send_item(OP_APPLY, 24'sh0, 24'sh0, 24'sh7FFFFF);
      send_item(OP_FILTER, 24'sh400000, 24'sh123456, 24'sh0);
      send_item(OP_APPLY, 24'sh0, 24'sh0, 24'sh800000);
      send_item(OP_FILTER, 24'shC00000, 24'shABCDEF, 24'sh0);
   endtask

   task automatic test_zero_energy();
      drain();
      write_csr(CSR_TAPS, 32'd8);
      write_csr(CSR_REG, 32'd0);
      write_csr(CSR_STEP, 32'd65535);
      send_item(OP_UPDATE, 24'sh0, 24'sh0, 24'sh7FFFFF);
      send_item(OP_PRECOMP, 24'sh0, 24'sh0, 24'sh0);
      send_item(OP_APPLY, 24'sh0, 24'sh0, 24'sh800000);
      send_item(OP_FILTER, 24'sh7FFFFF, 24'sh0, 24'sh0);
   endtask

   task automatic test_tap_limits();
      drain();
      write_csr(CSR_TAPS, 32'd0);          // acts as one tap
      write_csr(CSR_UNUSED, 32'hFFFFFFFF); // ignored
      write_csr(CSR_REG, 32'hFFFFFFFF);
      send_item(OP_FILTER, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh0);
      send_item(OP_UPDATE, 24'sh0, 24'sh0, 24'sh800000);
      send_item(OP_FILTER, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh0);
      drain();
      write_csr(CSR_TAPS, 32'h7F);         // clamps to the maximum
      write_csr(CSR_STEP, 32'd0);
      send_item(OP_FILTER, 24'sh555555, 24'shAAAAAA, 24'sh0);
      send_item(OP_UPDATE, 24'sh0, 24'sh0, 24'sh7FFFFF);
      send_item(OP_FILTER, 24'sh0, 24'sh0, 24'sh0);
   endtask

   task automatic test_random(int items, int taps, logic [31:0] step, logic [31:0] floor_val);
      int  pick;
      drain();
      write_csr(CSR_TAPS, taps);
      write_csr(CSR_STEP, step);
      write_csr(CSR_REG, floor_val);
      for (int i = 0; i < items; i++) begin
         pick = $urandom_range(99);
         if (pick < 55)      send_item(OP_FILTER, rand_sample(), rand_sample(), rand_sample());
         else if (pick < 75) send_item(OP_UPDATE, rand_sample(), rand_sample(), rand_sample());
         else if (pick < 87) send_item(OP_PRECOMP, rand_sample(), rand_sample(), rand_sample());
         else                send_item(OP_APPLY, rand_sample(), rand_sample(), rand_sample());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      ntaps = TAPS_MAX;
      mu = 16384;
      floor_energy = 429497;
      clear_filter();

      test_filter_extremes();
      test_two_phase();
      test_zero_energy();
      test_tap_limits();

      send_idle_pct = 13;
      recv_idle_pct = 71;
      test_random(95, 64, 16384, 429497);
      test_random(95, 1, 65535, 0);
      test_random(95, $urandom_range(63, 2), $urandom_range(65535), $urandom);
      send_idle_pct = 71;
      recv_idle_pct = 13;
      test_random(95, $urandom_range(16, 1), $urandom_range(65535), $urandom_range(1000000));
      test_random(95, 64, 0, 32'hFFFFFFFF);
      test_random(95, $urandom_range(64, 1), 65535, $urandom_range(1000));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(95, $urandom_range(8, 2), $urandom_range(65535), $urandom);
      test_random(95, 64, $urandom_range(65535), 429497);
      test_random(95, $urandom_range(64, 1), $urandom_range(65535), 0);

      wait (control_expected.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
